FILE: hdl/sfr_pkg.sv
package sfr_pkg;

    // Fixed widths of the request and result fields.
    localparam int SYMBOL_WIDTH = 8;
    localparam int OCC_WIDTH    = 24;
    localparam int SHARE_WIDTH  = 14;

    // Share scale: hundredths of a percent.
    localparam int SHARE_SCALE = 10000;

    // Defaults for the top-level parameters.
    localparam int DEF_TABLE_DEPTH = 32;
    localparam int DEF_COUNT_WIDTH = 24;

    // Request command codes.
    typedef enum logic {
        CMD_COUNT  = 1'b0,
        CMD_FINISH = 1'b1
    } sfr_cmd_t;

    typedef struct packed {
        sfr_cmd_t                  command;
        logic [SYMBOL_WIDTH-1:0]   symbol;
    } sfr_req_t;

    typedef struct packed {
        logic [SYMBOL_WIDTH-1:0]   out_symbol;
        logic [OCC_WIDTH-1:0]      occurrences;
        logic [SHARE_WIDTH-1:0]    percent_hundredths;
        logic                      empty_res;
        logic                      overflowed;
        logic                      last;
    } sfr_res_t;

    // Sequencer of the top level.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INSERT,
        ST_CNT_RD,
        ST_CNT_CMP,
        ST_RANK_RD,
        ST_RANK_CMP,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMPTY
    } sfr_state_t;

    // Sequencer of the share divider.
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_LOAD,
        DIV_STEP,
        DIV_DONE
    } sfr_div_state_t;

    // Status from the divider to the top-level sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } sfr_div_status_t;

endpackage

FILE: hdl/sfr_div.sv
module sfr_div #(
    parameter int COUNT_WIDTH = sfr_pkg::DEF_COUNT_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [COUNT_WIDTH-1:0]             count,
    input  logic [COUNT_WIDTH-1:0]             total,
    output logic [sfr_pkg::SHARE_WIDTH-1:0]    quotient,
    output sfr_pkg::sfr_div_status_t           status
);
    import sfr_pkg::*;

    localparam int PROD_WIDTH = COUNT_WIDTH + SHARE_WIDTH;
    localparam int STEP_WIDTH = $clog2(SHARE_WIDTH);
    localparam logic [STEP_WIDTH-1:0] STEP_LAST = STEP_WIDTH'(SHARE_WIDTH - 1);

    sfr_div_state_t state_reg, state_next;
    logic [PROD_WIDTH-1:0]  prod_reg, prod_next;
    logic [COUNT_WIDTH-1:0] den_reg, den_next;
    logic [COUNT_WIDTH-1:0] rem_reg, rem_next;
    logic [SHARE_WIDTH-1:0] low_reg, low_next;
    logic [SHARE_WIDTH-1:0] q_reg, q_next;
    logic [STEP_WIDTH-1:0]  step_reg, step_next;
    logic [COUNT_WIDTH:0]   trial;
    logic                   trial_ge;

    // One restoring step: bring down the next product bit and try the subtract.
    assign trial    = {rem_reg, low_reg[SHARE_WIDTH-1]};
    assign trial_ge = trial >= {1'b0, den_reg};

    // Next state of the divider sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    state_next = DIV_LOAD;
                end
            end
            DIV_LOAD:
            begin
                state_next = (den_reg == '0) ? DIV_DONE : DIV_STEP;
            end
            DIV_STEP:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE:
            begin
                state_next = DIV_IDLE;
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    // Datapath of the divider: one multiply, then one quotient bit a cycle.
    always_comb
    begin
        prod_next = prod_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        step_next = step_reg;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    prod_next = PROD_WIDTH'(count) * PROD_WIDTH'(SHARE_SCALE);
                    den_next  = total;
                end
            end
            DIV_LOAD:
            begin
                // The share is below 2^SHARE_WIDTH, so the high part is below the divisor.
                rem_next  = prod_reg[PROD_WIDTH-1:SHARE_WIDTH];
                low_next  = prod_reg[SHARE_WIDTH-1:0];
                q_next    = '0;
                step_next = '0;
            end
            DIV_STEP:
            begin
                rem_next  = trial_ge ? COUNT_WIDTH'(trial - {1'b0, den_reg})
                                     : COUNT_WIDTH'(trial);
                low_next  = {low_reg[SHARE_WIDTH-2:0], 1'b0};
                q_next    = {q_reg[SHARE_WIDTH-2:0], trial_ge};
                step_next = step_reg + 1'b1;
            end
            DIV_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Status outputs.
    always_comb
    begin
        status.busy = state_reg != DIV_IDLE;
        status.done = state_reg == DIV_DONE;
        quotient    = q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        q_reg    <= q_next;
    end

endmodule

FILE: hdl/symbol_frequency_ranker_core.sv
// Symbol frequency ranker.
// Requests enter on start/req and are taken at a clock edge where start is
// high and busy is low. A count request looks the byte up in the table and
// either bumps its count, inserts it with a count of one or, when the table
// is full, drops it and sets the overflow flag; it gives no result.
// A finish request emits every table entry, highest count first and ties in
// insertion order, each on result for one cycle with result_valid high. The
// final result has last set, and the table is then empty again.
// A count request's lookup reads the entry memory one entry at a time, with
// a read state and a compare state per entry; a miss ends in the insert
// state. The next request can be taken as soon as busy drops. For each rank
// of a finish the sequencer scans all entries for the next largest count,
// then the shared divider works out the percentage. Each result appears in
// the cycle after its divide ends. An empty finish passes through the EMPTY
// state and gives one result with empty_res set in the cycle after it.
// Reset clears the fill count, the total and the overflow flag; the entry
// memory needs no clearing. The receiver cannot stall: results never come in
// consecutive cycles and are lost if not taken when shown.
module symbol_frequency_ranker_core #(
    parameter int TABLE_DEPTH = sfr_pkg::DEF_TABLE_DEPTH,
    parameter int COUNT_WIDTH = sfr_pkg::DEF_COUNT_WIDTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sfr_pkg::sfr_req_t req,
    output logic              result_valid,
    output sfr_pkg::sfr_res_t result
);
    import sfr_pkg::*;

    localparam int IDX_WIDTH  = $clog2(TABLE_DEPTH);
    localparam int USED_WIDTH = $clog2(TABLE_DEPTH + 1);
    localparam logic [USED_WIDTH-1:0]  USED_FULL = USED_WIDTH'(TABLE_DEPTH);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    sfr_state_t state_reg, state_next;

    // Entry memory: symbol and count side by side, one write port and one read port.
    logic [SYMBOL_WIDTH-1:0] sym_mem [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0]  cnt_mem [TABLE_DEPTH];
    logic                    mem_we;
    logic [IDX_WIDTH-1:0]    mem_wa;
    logic [SYMBOL_WIDTH-1:0] mem_wsym;
    logic [COUNT_WIDTH-1:0]  mem_wcnt;
    logic [SYMBOL_WIDTH-1:0] rd_sym_reg;
    logic [COUNT_WIDTH-1:0]  rd_cnt_reg;

    logic [USED_WIDTH-1:0]   used_reg, used_next;
    logic [COUNT_WIDTH-1:0]  total_reg, total_next;
    logic                    ovf_reg, ovf_next;
    logic [SYMBOL_WIDTH-1:0] sym_reg, sym_next;
    logic [IDX_WIDTH-1:0]    scan_idx_reg, scan_idx_next;
    logic [USED_WIDTH-1:0]   rank_reg, rank_next;
    logic                    have_best_reg, have_best_next;
    logic [COUNT_WIDTH-1:0]  best_cnt_reg, best_cnt_next;
    logic [IDX_WIDTH-1:0]    best_idx_reg, best_idx_next;
    logic [SYMBOL_WIDTH-1:0] best_sym_reg, best_sym_next;
    logic [COUNT_WIDTH-1:0]  prev_cnt_reg, prev_cnt_next;
    logic [IDX_WIDTH-1:0]    prev_idx_reg, prev_idx_next;
    logic                    res_valid_reg, res_valid_next;
    sfr_res_t                res_reg, res_next;

    logic                    accept;
    logic                    scan_end;
    logic                    sym_match;
    logic                    eligible;
    logic                    last_rank;
    logic [COUNT_WIDTH-1:0]  total_inc;
    logic [COUNT_WIDTH-1:0]  rd_cnt_inc;

    logic                    div_start;
    logic [SHARE_WIDTH-1:0]  div_quot;
    sfr_div_status_t         div_status;

    // Shared share divider.
    sfr_div #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .count    (best_cnt_reg),
        .total    (total_reg),
        .quotient (div_quot),
        .status   (div_status)
    );

    // Common conditions of the sequencer.
    assign accept     = start && !busy;
    assign scan_end   = scan_idx_reg == IDX_WIDTH'(used_reg - 1'b1);
    assign sym_match  = rd_sym_reg == sym_reg;
    assign last_rank  = USED_WIDTH'(rank_reg + 1'b1) == used_reg;
    assign total_inc  = (total_reg == COUNT_MAX) ? total_reg : total_reg + 1'b1;
    assign rd_cnt_inc = (rd_cnt_reg == COUNT_MAX) ? rd_cnt_reg : rd_cnt_reg + 1'b1;

    // An entry may take this rank if it comes after the previous rank's entry
    // in the order of larger count first, then earlier insertion.
    assign eligible = (rank_reg == '0) || (rd_cnt_reg < prev_cnt_reg) ||
                      ((rd_cnt_reg == prev_cnt_reg) && (scan_idx_reg > prev_idx_reg));

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.command == CMD_FINISH)
                    begin
                        state_next = (used_reg == '0) ? ST_EMPTY : ST_RANK_RD;
                    end
                    else
                    begin
                        state_next = (used_reg == '0) ? ST_INSERT : ST_CNT_RD;
                    end
                end
            end
            ST_INSERT:
            begin
                state_next = ST_IDLE;
            end
            ST_CNT_RD:
            begin
                state_next = ST_CNT_CMP;
            end
            ST_CNT_CMP:
            begin
                if (sym_match)
                begin
                    state_next = ST_IDLE;
                end
                else if (scan_end)
                begin
                    state_next = ST_INSERT;
                end
                else
                begin
                    state_next = ST_CNT_RD;
                end
            end
            ST_RANK_RD:
            begin
                state_next = ST_RANK_CMP;
            end
            ST_RANK_CMP:
            begin
                state_next = scan_end ? ST_DIV_START : ST_RANK_RD;
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_status.done)
                begin
                    state_next = last_rank ? ST_IDLE : ST_RANK_RD;
                end
            end
            ST_EMPTY:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and result updates for each state.
    always_comb
    begin
        used_next      = used_reg;
        total_next     = total_reg;
        ovf_next       = ovf_reg;
        sym_next       = sym_reg;
        scan_idx_next  = scan_idx_reg;
        rank_next      = rank_reg;
        have_best_next = have_best_reg;
        best_cnt_next  = best_cnt_reg;
        best_idx_next  = best_idx_reg;
        best_sym_next  = best_sym_reg;
        prev_cnt_next  = prev_cnt_reg;
        prev_idx_next  = prev_idx_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_wa         = scan_idx_reg;
        mem_wsym       = sym_reg;
        mem_wcnt       = rd_cnt_inc;
        div_start      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sym_next       = req.symbol;
                    scan_idx_next  = '0;
                    rank_next      = '0;
                    have_best_next = 1'b0;
                end
            end
            ST_INSERT:
            begin
                // A new symbol goes to the next free slot, or is dropped when full.
                if (used_reg == USED_FULL)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_wa     = IDX_WIDTH'(used_reg);
                    mem_wcnt   = COUNT_WIDTH'(1);
                    used_next  = used_reg + 1'b1;
                    total_next = total_inc;
                end
            end
            ST_CNT_RD:
            begin
            end
            ST_CNT_CMP:
            begin
                if (sym_match)
                begin
                    mem_we     = 1'b1;
                    total_next = total_inc;
                end
                else if (!scan_end)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_RANK_RD:
            begin
            end
            ST_RANK_CMP:
            begin
                // Keep the first largest eligible count of this pass.
                if (eligible && (!have_best_reg || (rd_cnt_reg > best_cnt_reg)))
                begin
                    have_best_next = 1'b1;
                    best_cnt_next  = rd_cnt_reg;
                    best_idx_next  = scan_idx_reg;
                    best_sym_next  = rd_sym_reg;
                end
                if (!scan_end)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_DIV_START:
            begin
                div_start = 1'b1;
            end
            ST_DIV_WAIT:
            begin
                if (div_status.done)
                begin
                    res_valid_next              = 1'b1;
                    res_next.out_symbol         = best_sym_reg;
                    res_next.occurrences        = OCC_WIDTH'(best_cnt_reg);
                    res_next.percent_hundredths = div_quot;
                    res_next.empty_res          = 1'b0;
                    res_next.overflowed         = ovf_reg;
                    res_next.last               = last_rank;
                    prev_cnt_next               = best_cnt_reg;
                    prev_idx_next               = best_idx_reg;
                    rank_next                   = rank_reg + 1'b1;
                    scan_idx_next               = '0;
                    have_best_next              = 1'b0;
                    if (last_rank)
                    begin
                        used_next  = '0;
                        total_next = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            ST_EMPTY:
            begin
                res_valid_next              = 1'b1;
                res_next.out_symbol         = '0;
                res_next.occurrences        = '0;
                res_next.percent_hundredths = '0;
                res_next.empty_res          = 1'b1;
                res_next.overflowed         = ovf_reg;
                res_next.last               = 1'b1;
                used_next                   = '0;
                total_next                  = '0;
                ovf_next                    = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // Port outputs.
    assign busy         = state_reg != ST_IDLE;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Entry memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sym_mem[mem_wa] <= mem_wsym;
            cnt_mem[mem_wa] <= mem_wcnt;
        end
        rd_sym_reg <= sym_mem[scan_idx_reg];
        rd_cnt_reg <= cnt_mem[scan_idx_reg];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            scan_idx_reg  <= '0;
            rank_reg      <= '0;
            have_best_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            total_reg     <= total_next;
            ovf_reg       <= ovf_next;
            scan_idx_reg  <= scan_idx_next;
            rank_reg      <= rank_next;
            have_best_reg <= have_best_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sym_reg      <= sym_next;
        best_cnt_reg <= best_cnt_next;
        best_idx_reg <= best_idx_next;
        best_sym_reg <= best_sym_next;
        prev_cnt_reg <= prev_cnt_next;
        prev_idx_reg <= prev_idx_next;
        res_reg      <= res_next;
    end

    // The fill count never passes the table depth.
    assert property (@(posedge clk) disable iff (!rst_n) used_reg <= USED_FULL)
        else $error("fill count beyond table depth");

    // A final result leaves an empty table behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> used_reg == '0 && total_reg == '0 && !ovf_reg)
        else $error("table not cleared after final result");

    // Results are never shown in consecutive cycles.
    assert property (@(posedge clk) disable iff (!rst_n) result_valid |=> !result_valid)
        else $error("back-to-back result strobes");

    // An accepted request always makes the block busy.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> busy)
        else $error("request accepted without leaving idle");

endmodule

FILE: verif/sfr_rank_checker.sv
// Watches the request and result channels of the frequency ranker, keeps its
// own copy of the symbol table and checks every ranked result in order.
module sfr_rank_checker #(
    parameter int TABLE_DEPTH = sfr_pkg::DEF_TABLE_DEPTH,
    parameter int COUNT_WIDTH = sfr_pkg::DEF_COUNT_WIDTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  sfr_pkg::sfr_req_t req,
    input  logic              result_valid,
    input  sfr_pkg::sfr_res_t result,
    output int                mismatches,
    output int                pending_results
);

    // Mirror of the symbol table; slot order is insertion order.
    logic [sfr_pkg::SYMBOL_WIDTH-1:0] slot_symbol [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0]           slot_count [TABLE_DEPTH];
    int                               slots_filled;
    logic [COUNT_WIDTH-1:0]           byte_total;
    logic                             dropped_new;

    // Ranked results still due from the block, oldest first.
    sfr_pkg::sfr_res_t ranked_due [$];

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void wipe_table();
        slots_filled = 0;
        byte_total   = '0;
        dropped_new  = 1'b0;
    endfunction

    // A count request either bumps a matching slot, takes a fresh slot, or is
    // dropped when the table is full.
    task automatic tally_symbol(input logic [sfr_pkg::SYMBOL_WIDTH-1:0] sym);
        bit found;
        found = 1'b0;
        for (int i = 0; i < slots_filled; i++)
        begin
            if (!found && slot_symbol[i] == sym)
            begin
                slot_count[i] = bump(slot_count[i]);
                found = 1'b1;
            end
        end
        if (found)
        begin
            byte_total = bump(byte_total);
        end
        else if (slots_filled < TABLE_DEPTH)
        begin
            slot_symbol[slots_filled] = sym;
            slot_count[slots_filled]  = COUNT_WIDTH'(1);
            slots_filled++;
            byte_total = bump(byte_total);
        end
        else
        begin
            dropped_new = 1'b1;
        end
    endtask

    // A finish request ranks the slots by count, highest first with ties in
    // insertion order, queues one result per slot and empties the table.
    task automatic queue_ranking();
        int                order [TABLE_DEPTH];
        int                j;
        int                cur;
        longint unsigned   share;
        sfr_pkg::sfr_res_t res;
        res = '0;
        res.overflowed = dropped_new;
        if (slots_filled == 0)
        begin
            res.empty_res = 1'b1;
            res.last      = 1'b1;
            ranked_due.push_back(res);
        end
        else
        begin
            for (int i = 0; i < slots_filled; i++)
                order[i] = i;
            // Stable insertion sort, descending by count.
            for (int i = 1; i < slots_filled; i++)
            begin
                cur = order[i];
                j = i;
                while (j > 0 && slot_count[order[j-1]] < slot_count[cur])
                begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = cur;
            end
            for (int k = 0; k < slots_filled; k++)
            begin
                share = 0;
                if (byte_total != 0)
                    share = (longint'(slot_count[order[k]]) * sfr_pkg::SHARE_SCALE)
                            / longint'(byte_total);
                res.out_symbol         = slot_symbol[order[k]];
                res.occurrences        = sfr_pkg::OCC_WIDTH'(slot_count[order[k]]);
                res.percent_hundredths = sfr_pkg::SHARE_WIDTH'(share);
                res.last               = (k == slots_filled - 1);
                ranked_due.push_back(res);
            end
        end
        wipe_table();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Results are checked before the request of the same edge is applied,
    // since a result at that edge always belongs to an earlier finish.
    always @(posedge clk or negedge rst_n)
    begin : watch
        sfr_pkg::sfr_res_t due;
        if (!rst_n)
        begin
            wipe_table();
            ranked_due.delete();
            mismatches = 0;
            pending_results <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (ranked_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %0h",
                             $time, result);
                    mismatches++;
                end
                else
                begin
                    due = ranked_due.pop_front();
                    check_field("out_symbol", 32'(due.out_symbol),
                                32'(result.out_symbol));
                    check_field("occurrences", 32'(due.occurrences),
                                32'(result.occurrences));
                    check_field("percent_hundredths", 32'(due.percent_hundredths),
                                32'(result.percent_hundredths));
                    check_field("empty_res", 32'(due.empty_res),
                                32'(result.empty_res));
                    check_field("overflowed", 32'(due.overflowed),
                                32'(result.overflowed));
                    check_field("last", 32'(due.last), 32'(result.last));
                end
            end
            if (start && !busy)
            begin
                if (req.command == sfr_pkg::CMD_FINISH)
                    queue_ranking();
                else
                    tally_symbol(req.symbol);
            end
            pending_results <= ranked_due.size();
        end
    end

endmodule

FILE: verif/tb_top.sv
// Drives count and finish requests into the frequency ranker; the checker
// beside the block predicts and compares the ranked results.
module tb_top;

    localparam int TABLE_DEPTH    = sfr_pkg::DEF_TABLE_DEPTH;
    localparam int COUNT_WIDTH    = sfr_pkg::DEF_COUNT_WIDTH;
    localparam int REQUEST_BUDGET = 330;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 200;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    sfr_pkg::sfr_req_t req;
    logic              result_valid;
    sfr_pkg::sfr_res_t result;
    int                mismatches;
    int                pending_results;
    int                requests_sent = 0;
    int                quiet_cycles = 0;
    bit                burst_mode = 0;

    symbol_frequency_ranker_core #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .result_valid (result_valid),
        .result       (result)
    );

    sfr_rank_checker #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) rank_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req             (req),
        .result_valid    (result_valid),
        .result          (result),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: too long without any request or result taken ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Mostly back-to-back or short gaps, now and then a long one. While
    // start is low the request bus carries junk.
    task automatic pause_sender();
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (burst_mode || pick < 45)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 60);
        if (gap > 0)
        begin
            start <= 1'b0;
            req   <= sfr_pkg::sfr_req_t'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds a request until the block takes it, then may idle for a while.
    task automatic send_request(input sfr_pkg::sfr_cmd_t cmd,
                                input logic [sfr_pkg::SYMBOL_WIDTH-1:0] sym);
        sfr_pkg::sfr_req_t r;
        r.command = cmd;
        r.symbol  = sym;
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        requests_sent++;
        pause_sender();
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [sfr_pkg::SYMBOL_WIDTH-1:0] alphabet [6];
        logic [sfr_pkg::SYMBOL_WIDTH-1:0] base;
        logic [sfr_pkg::SYMBOL_WIDTH-1:0] stride;
        sfr_pkg::sfr_cmd_t                cmd;
        int                               kind;
        int                               letters;
        int                               len;
        int                               extra;

        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Finish on an empty table right after reset.
        send_request(sfr_pkg::CMD_FINISH, 8'hFF);
        // Zero byte must not match empty slots; top tie resolved by insertion.
        send_request(sfr_pkg::CMD_COUNT, 8'h00);
        send_request(sfr_pkg::CMD_COUNT, 8'hFF);
        send_request(sfr_pkg::CMD_COUNT, 8'h00);
        send_request(sfr_pkg::CMD_COUNT, 8'hAA);
        send_request(sfr_pkg::CMD_COUNT, 8'h55);
        send_request(sfr_pkg::CMD_COUNT, 8'hFF);
        send_request(sfr_pkg::CMD_FINISH, 8'h00);
        // The table was cleared, so this finish is empty again.
        send_request(sfr_pkg::CMD_FINISH, 8'h00);
        // A lone symbol holds the whole share.
        send_request(sfr_pkg::CMD_COUNT, 8'h80);
        send_request(sfr_pkg::CMD_COUNT, 8'h80);
        send_request(sfr_pkg::CMD_COUNT, 8'h80);
        send_request(sfr_pkg::CMD_FINISH, 8'h7F);
        wait_drained();

        // Random part: mostly count runs closed by a finish.
        while (requests_sent < REQUEST_BUDGET)
        begin
            kind = $urandom_range(0, 99);
            burst_mode = ($urandom_range(0, 5) == 0);
            if (kind < 8)
            begin
                // Fill every slot, with repeats, and often push past full.
                base   = 8'($urandom);
                stride = 8'($urandom_range(0, 127) * 2 + 1);
                extra  = $urandom_range(0, 4);
                for (int i = 0; i < TABLE_DEPTH + extra; i++)
                begin
                    send_request(sfr_pkg::CMD_COUNT, 8'(base + i * stride));
                    if ($urandom_range(0, 3) == 0)
                        send_request(sfr_pkg::CMD_COUNT,
                                     8'(base + $urandom_range(0, i) * stride));
                end
                send_request(sfr_pkg::CMD_FINISH, 8'($urandom));
            end
            else if (kind < 18)
            begin
                send_request(sfr_pkg::CMD_FINISH, 8'($urandom));
            end
            else if (kind < 32)
            begin
                // Noise: any mix of counts and finishes.
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                begin
                    cmd = ($urandom_range(0, 3) == 0) ? sfr_pkg::CMD_FINISH
                                                      : sfr_pkg::CMD_COUNT;
                    send_request(cmd, 8'($urandom));
                end
            end
            else
            begin
                // A few symbols drawn many times, so counts differ and tie.
                letters = $urandom_range(1, 6);
                for (int i = 0; i < letters; i++)
                begin
                    case ($urandom_range(0, 9))
                        0: alphabet[i] = 8'h00;
                        1: alphabet[i] = 8'hFF;
                        default: alphabet[i] = 8'($urandom);
                    endcase
                end
                len = $urandom_range(1, 14);
                for (int i = 0; i < len; i++)
                    send_request(sfr_pkg::CMD_COUNT,
                                 alphabet[$urandom_range(0, letters - 1)]);
                send_request(sfr_pkg::CMD_FINISH, 8'($urandom));
            end
            if ($urandom_range(0, 6) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: symbol_frequency_ranker_core.f
hdl/sfr_pkg.sv
hdl/sfr_div.sv
hdl/symbol_frequency_ranker_core.sv
verif/sfr_rank_checker.sv
verif/tb_top.sv
